FILE: hw/rtl/save_ram_dirty_chunk_writeback_core_macros.svh
// Assertion macros shared by the save-RAM write-back core and its helpers.
// Each macro samples on clk and is disabled while rst is high.
`ifndef SAVE_RAM_DIRTY_CHUNK_WRITEBACK_CORE_MACROS_SVH
`define SAVE_RAM_DIRTY_CHUNK_WRITEBACK_CORE_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define SRDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SRDC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/srdc_pkg.sv
// Shared types and codes of the save-RAM dirty-chunk write-back core.
// No dependencies; imported by srdc_rem and the top level.
`timescale 1ns / 1ps

package srdc_pkg;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // Configuration register indexes
  localparam logic REG_SAVE_SIZE    = 1'b0;
  localparam logic REG_ROM_CHECKSUM = 1'b1;

  localparam logic [31:0] KEY_PREFIX      = 32'h5000_0000;
  localparam logic [7:0]  ERASED_BYTE     = 8'hFF;
  localparam logic [15:0] SAVE_SIZE_RESET = 16'h8000;

  typedef struct packed {
    logic [1:0]  op;
    logic [14:0] address;
    logic [7:0]  byte_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic        accepted;
    logic [31:0] chunk_key;
    logic [5:0]  byte_offset;
    logic        last;
    logic [9:0]  dirty_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP_RD,
    ST_SWEEP_WR,
    ST_FL_MOD,
    ST_FL_RD,
    ST_FL_CHK,
    ST_FL_START,
    ST_FL_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

endpackage

FILE: hw/rtl/srdc_rem.sv
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on srdc_pkg (rem_status_t) and the core macros header.
`timescale 1ns / 1ps
`include "save_ram_dirty_chunk_writeback_core_macros.svh"

module srdc_rem import srdc_pkg::*; #(
  parameter int W = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output rem_status_t status,
  output logic [W-1:0] remainder
);

  localparam int CTW = $clog2(W + 1);

  logic [W:0]     part;
  logic [W:0]     trial;
  logic [W:0]     part_next;
  logic [W-1:0]   shreg;
  logic [W-1:0]   div_q;
  logic [CTW-1:0] steps;
  logic           busy;
  logic           done;

  // Shift in the next dividend bit, subtract when it fits.
  always_comb begin
    trial = {part[W-1:0], shreg[W-1]};
    if (trial >= {1'b0, div_q}) begin
      part_next = trial - {1'b0, div_q};
    end else begin
      part_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CTW'(W);
      end else if (busy) begin
        steps <= steps - CTW'(1);
        if (steps == CTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part  <= '0;
      shreg <= dividend;
      div_q <= divisor;
    end else if (busy) begin
      part  <= part_next;
      shreg <= shreg << 1;
    end
  end

  assign status    = '{busy: busy, done: done};
  assign remainder = part[W-1:0];

  `SRDC_ASSERT(a_rem_below_divisor, done |-> (part < {1'b0, div_q}), "remainder not below divisor")
  `SRDC_NEVER(a_rem_start_busy, start && busy, "remainder unit restarted while busy")
  `SRDC_ASSERT(a_rem_done_pulse, done |=> !done, "remainder done held longer than one cycle")

endmodule

FILE: hw/rtl/save_ram_dirty_chunk_writeback_core.sv
// Top level of the save-RAM write-back buffer with a per-chunk dirty bitmap.
// Depends on srdc_pkg, srdc_rem and the core macros header.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------
//   in       | input     | in_valid / in_stall   | in_data  (in_item_t)
//   out      | output    | out_valid / out_stall | out_data (out_item_t)
//   cfg      | input     | cfg_we (no wait)      | cfg_index, cfg_data
//
// Read, write and load pass through accept (memory read issued) and an
// execute state that writes back and loads the output register.
// Flush folds the cursor into range after accept, scans the dirty memory with
// a read and a check state per chunk, fetches the first byte, then emits one
// byte per free output slot; with nothing dirty, or no chunk in use, the
// execute state follows instead.
// After reset a clearing pass fills the byte memory with 0xFF and clears the
// dirty memory; in_stall stays high meanwhile. A save_size write whose chunk
// count is below NUM_CHUNKS sweeps the dirty memory from the new chunk count
// to the end, a read and a write state per chunk, with in_stall high.
// out_stall holds the output register; a new result waits until it is free.
`timescale 1ns / 1ps
`include "save_ram_dirty_chunk_writeback_core_macros.svh"

module save_ram_dirty_chunk_writeback_core import srdc_pkg::*; #(
  parameter int SAVE_BYTES  = 32768,
  parameter int CHUNK_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NUM_CHUNKS  = (SAVE_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int AW          = $clog2(SAVE_BYTES);
  localparam int SW          = $clog2(SAVE_BYTES + 1);
  localparam int CIW         = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int CNW         = $clog2(NUM_CHUNKS + 1);
  // Reciprocal divide by CHUNK_BYTES, exact for every value below 2**DIV_N.
  localparam int DIV_N       = SW + 1;
  localparam int DIV_K       = DIV_N + $clog2(CHUNK_BYTES);
  localparam int DIV_M       = ((1 << DIV_K) + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int MW          = $clog2(DIV_M + 1);
  localparam int USED_RESET  = (SAVE_BYTES < 32768) ? SAVE_BYTES : 32768;
  localparam int LIMIT_RESET = (USED_RESET + CHUNK_BYTES - 1) / CHUNK_BYTES;

  function automatic logic [CNW-1:0] chunk_of(input logic [DIV_N-1:0] x);
    logic [DIV_N+MW-1:0] prod;
    prod = (DIV_N+MW)'(x) * (DIV_N+MW)'(DIV_M);
    return CNW'(prod >> DIV_K);
  endfunction

  function automatic logic [SW-1:0] clamp_size(input logic [15:0] v);
    if (32'(v) > 32'(SAVE_BYTES)) begin
      return SW'(SAVE_BYTES);
    end else begin
      return SW'(v);
    end
  endfunction

  // Control state
  state_t          state;
  state_t          state_next;
  logic [15:0]     save_size;
  logic [15:0]     cart_sum;
  logic [CNW-1:0]  chunk_limit;
  logic [SW-1:0]   init_ctr;
  logic [SW-1:0]   init_ctr_next;
  logic [CNW-1:0]  dirty_total;
  logic [CNW-1:0]  dirty_total_next;
  logic [CIW-1:0]  scan_origin;
  logic [CIW-1:0]  scan_origin_next;
  logic [CNW-1:0]  sweep_ptr;
  logic [CNW-1:0]  sweep_ptr_next;
  logic [CNW-1:0]  sweep_from;

  // Transaction payload held during execution
  in_item_t        item;
  logic            item_inr;
  logic [CIW-1:0]  item_chunk;
  logic [CIW-1:0]  scan_c;
  logic [CIW-1:0]  scan_c_next;
  logic [CNW-1:0]  scan_i;
  logic [CNW-1:0]  scan_i_next;
  logic [AW-1:0]   flush_addr;
  logic [AW-1:0]   flush_addr_next;
  logic [CIW-1:0]  flush_chunk;
  logic [CIW-1:0]  flush_chunk_next;
  logic [5:0]      flush_off;
  logic [5:0]      flush_off_next;

  // Decode
  logic [SW-1:0]   used_size;
  logic [SW-1:0]   new_used;
  logic [CNW-1:0]  new_limit;
  logic            size_wr;
  logic            in_fire;
  logic            in_inr;
  logic [CNW-1:0]  in_chunk;
  logic            out_free;
  logic            scan_last;
  logic [CNW-1:0]  scan_c_inc;
  logic [CIW-1:0]  scan_wrap;
  logic            emit_last;
  logic            write_acc;
  logic [31:0]     flush_key;

  // Output register load
  logic            push;
  out_item_t       push_item;

  // Memories and their ports
  logic [7:0]      save_mem [SAVE_BYTES];
  logic            dirty_mem [NUM_CHUNKS];
  logic            byte_re;
  logic [AW-1:0]   byte_raddr;
  logic [7:0]      byte_rd;
  logic            byte_we;
  logic [AW-1:0]   byte_waddr;
  logic [7:0]      byte_wdata;
  logic            dirty_re;
  logic [CIW-1:0]  dirty_raddr;
  logic            dirty_rd;
  logic            dirty_we;
  logic [CIW-1:0]  dirty_waddr;
  logic            dirty_wdata;

  // Remainder unit for the flush cursor
  logic            rem_start;
  rem_status_t     rem_st;
  logic [CNW-1:0]  rem_value;

  srdc_rem #(
    .W(CNW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (CNW'(scan_origin)),
    .divisor  (chunk_limit),
    .status   (rem_st),
    .remainder(rem_value)
  );

  // ---------------------------------------------------------------------
  // Decode of configuration, input and scan position
  // ---------------------------------------------------------------------
  assign used_size  = clamp_size(save_size);
  assign new_used   = clamp_size(cfg_data);
  assign new_limit  = chunk_of(DIV_N'(new_used) + DIV_N'(CHUNK_BYTES - 1));
  assign size_wr    = cfg_we && (cfg_index == REG_SAVE_SIZE);

  // Hold inputs while busy, and in the cycle of a size write so the new
  // size applies before the next transaction.
  assign in_stall   = (state != ST_IDLE) || size_wr;
  assign in_fire    = in_valid && !in_stall;
  assign in_inr     = 32'(in_data.address) < 32'(used_size);
  assign in_chunk   = chunk_of(DIV_N'(in_data.address));
  assign rem_start  = in_fire && (in_data.op == OP_FLUSH) && (chunk_limit != '0);

  assign out_free   = !out_valid || !out_stall;

  assign scan_last  = (scan_i + CNW'(1)) == chunk_limit;
  assign scan_c_inc = CNW'(scan_c) + CNW'(1);
  assign scan_wrap  = (scan_c_inc == chunk_limit) ? '0 : CIW'(scan_c_inc);

  assign emit_last  = (flush_off == 6'(CHUNK_BYTES - 1)) ||
                      ((SW'(flush_addr) + SW'(1)) == used_size);
  assign flush_key  = KEY_PREFIX | {8'h00, cart_sum, 8'h00} | 32'(flush_chunk);
  assign write_acc  = item_inr && (byte_rd != item.byte_in);

  // Sweep restart: keep the lowest chunk still owed a clear.
  always_comb begin
    sweep_from = sweep_ptr;
    if (state == ST_SWEEP_WR) begin
      sweep_from = sweep_ptr + CNW'(1);
    end
    sweep_ptr_next = sweep_ptr;
    case (state)
      ST_IDLE: begin
        if (size_wr) begin
          sweep_ptr_next = new_limit;
        end
      end
      ST_SWEEP_RD, ST_SWEEP_WR: begin
        if (size_wr && (new_limit < sweep_from)) begin
          sweep_ptr_next = new_limit;
        end else begin
          sweep_ptr_next = sweep_from;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (init_ctr == SW'(SAVE_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (size_wr) begin
          if (new_limit < CNW'(NUM_CHUNKS)) begin
            state_next = ST_SWEEP_RD;
          end
        end else if (in_fire) begin
          if (rem_start) begin
            state_next = ST_FL_MOD;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_SWEEP_RD: begin
        // A size write here drops the read in flight and restarts the sweep
        if (size_wr) begin
          state_next = ST_SWEEP_RD;
        end else begin
          state_next = ST_SWEEP_WR;
        end
      end
      ST_SWEEP_WR: begin
        if (sweep_ptr_next < CNW'(NUM_CHUNKS)) begin
          state_next = ST_SWEEP_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FL_MOD: begin
        if (rem_st.done) begin
          state_next = ST_FL_RD;
        end
      end
      ST_FL_RD: begin
        state_next = ST_FL_CHK;
      end
      ST_FL_CHK: begin
        if (dirty_rd) begin
          state_next = ST_FL_START;
        end else if (scan_last) begin
          state_next = ST_EXEC;
        end else begin
          state_next = ST_FL_RD;
        end
      end
      ST_FL_START: begin
        state_next = ST_FL_EMIT;
      end
      ST_FL_EMIT: begin
        if (out_free && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Memory control, bookkeeping and results
  // ---------------------------------------------------------------------
  always_comb begin
    init_ctr_next     = init_ctr;
    dirty_total_next  = dirty_total;
    scan_origin_next  = scan_origin;
    scan_c_next       = scan_c;
    scan_i_next       = scan_i;
    flush_addr_next   = flush_addr;
    flush_chunk_next  = flush_chunk;
    flush_off_next    = flush_off;

    byte_re     = 1'b0;
    byte_raddr  = AW'(in_data.address);
    byte_we     = 1'b0;
    byte_waddr  = AW'(item.address);
    byte_wdata  = item.byte_in;
    dirty_re    = 1'b0;
    dirty_raddr = CIW'(in_chunk);
    dirty_we    = 1'b0;
    dirty_waddr = item_chunk;
    dirty_wdata = 1'b1;

    push      = 1'b0;
    push_item = '{kind: KIND_STATUS, byte_out: 8'h00, accepted: 1'b0,
                  chunk_key: 32'h0, byte_offset: 6'd0, last: 1'b1,
                  dirty_count: 10'(dirty_total)};

    case (state)
      ST_INIT: begin
        // Erase one byte and one dirty bit per cycle
        byte_we       = 1'b1;
        byte_waddr    = AW'(init_ctr);
        byte_wdata    = ERASED_BYTE;
        dirty_we      = 32'(init_ctr) < 32'(NUM_CHUNKS);
        dirty_waddr   = CIW'(init_ctr);
        dirty_wdata   = 1'b0;
        init_ctr_next = init_ctr + SW'(1);
      end
      ST_IDLE: begin
        // Fetch the addressed byte and its chunk's dirty bit on accept
        if (in_fire) begin
          byte_re  = 1'b1;
          dirty_re = 1'b1;
        end
      end
      ST_SWEEP_RD: begin
        dirty_re    = 1'b1;
        dirty_raddr = CIW'(sweep_ptr);
      end
      ST_SWEEP_WR: begin
        if (dirty_rd) begin
          dirty_we         = 1'b1;
          dirty_waddr      = CIW'(sweep_ptr);
          dirty_wdata      = 1'b0;
          dirty_total_next = dirty_total - CNW'(1);
        end
      end
      ST_EXEC: begin
        // Write back only in the cycle the result enters the output register
        if (out_free) begin
          push = 1'b1;
          case (item.op)
            OP_READ: begin
              push_item.kind     = KIND_READ;
              push_item.byte_out = item_inr ? byte_rd : ERASED_BYTE;
            end
            OP_WRITE: begin
              if (write_acc) begin
                byte_we = 1'b1;
                if (!dirty_rd) begin
                  dirty_we         = 1'b1;
                  dirty_total_next = dirty_total + CNW'(1);
                end
              end
              push_item.accepted    = write_acc;
              push_item.dirty_count = 10'(dirty_total_next);
            end
            OP_LOAD: begin
              byte_we            = item_inr;
              push_item.accepted = item_inr;
            end
            OP_FLUSH: begin
              push_item.kind = KIND_NONE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FL_MOD: begin
        if (rem_st.done) begin
          scan_c_next = CIW'(rem_value);
          scan_i_next = '0;
        end
      end
      ST_FL_RD: begin
        dirty_re    = 1'b1;
        dirty_raddr = scan_c;
      end
      ST_FL_CHK: begin
        if (dirty_rd) begin
          // Claim the chunk: clear its bit and move the cursor past it
          dirty_we          = 1'b1;
          dirty_waddr       = scan_c;
          dirty_wdata       = 1'b0;
          dirty_total_next  = dirty_total - CNW'(1);
          scan_origin_next  = scan_wrap;
          flush_chunk_next  = scan_c;
          flush_addr_next   = AW'(32'(scan_c) * CHUNK_BYTES);
          flush_off_next    = '0;
        end else begin
          scan_c_next = scan_wrap;
          scan_i_next = scan_i + CNW'(1);
        end
      end
      ST_FL_START: begin
        byte_re    = 1'b1;
        byte_raddr = flush_addr;
      end
      ST_FL_EMIT: begin
        // Emit one byte per free output slot, prefetch the next one
        if (out_free) begin
          push      = 1'b1;
          push_item = '{kind: KIND_FLUSH, byte_out: byte_rd, accepted: 1'b0,
                        chunk_key: flush_key, byte_offset: flush_off,
                        last: emit_last, dirty_count: 10'(dirty_total)};
          if (!emit_last) begin
            flush_addr_next = flush_addr + AW'(1);
            flush_off_next  = flush_off + 6'd1;
            byte_re         = 1'b1;
            byte_raddr      = flush_addr + AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      init_ctr     <= '0;
      dirty_total  <= '0;
      scan_origin  <= '0;
      sweep_ptr    <= '0;
      save_size    <= SAVE_SIZE_RESET;
      cart_sum     <= '0;
      chunk_limit  <= CNW'(LIMIT_RESET);
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      init_ctr     <= init_ctr_next;
      dirty_total  <= dirty_total_next;
      scan_origin  <= scan_origin_next;
      sweep_ptr    <= sweep_ptr_next;
      out_valid    <= push || (out_valid && out_stall);
      if (cfg_we) begin
        case (cfg_index)
          REG_SAVE_SIZE: begin
            save_size   <= cfg_data;
            chunk_limit <= new_limit;
          end
          REG_ROM_CHECKSUM: begin
            cart_sum <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item       <= in_data;
      item_inr   <= in_inr;
      item_chunk <= CIW'(in_chunk);
    end
    scan_c      <= scan_c_next;
    scan_i      <= scan_i_next;
    flush_addr  <= flush_addr_next;
    flush_chunk <= flush_chunk_next;
    flush_off   <= flush_off_next;
    if (push) begin
      out_data <= push_item;
    end
  end

  // Byte memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (byte_we) begin
      save_mem[byte_waddr] <= byte_wdata;
    end
    if (byte_re) begin
      byte_rd <= save_mem[byte_raddr];
    end
  end

  // Dirty bitmap memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (dirty_we) begin
      dirty_mem[dirty_waddr] <= dirty_wdata;
    end
    if (dirty_re) begin
      dirty_rd <= dirty_mem[dirty_raddr];
    end
  end

  `SRDC_NEVER(a_no_overwrite, push && out_valid && out_stall, "result overwrote a stalled output")
  `SRDC_ASSERT(a_dirty_bound, dirty_total <= CNW'(NUM_CHUNKS), "dirty count above chunk count")
  `SRDC_ASSERT(a_scan_range, (state == ST_FL_CHK) |-> (CNW'(scan_c) < chunk_limit), "scan past end")
  `SRDC_ASSERT(a_rem_owner, rem_st.done |-> (state == ST_FL_MOD), "remainder done outside cursor fold")
  `SRDC_NEVER(a_rem_idle, rem_st.busy && (state != ST_FL_MOD), "remainder busy outside fold")

endmodule

FILE: test/tb_top.sv
// Self-checking bench for the save-RAM write-back core with its dirty-chunk bitmap.
// Depends on srdc_pkg and save_ram_dirty_chunk_writeback_core. A shadow copy of
// the save bytes, the dirty bits and the flush cursor predicts every response.
`timescale 1ns / 1ps

module tb_top;
  import srdc_pkg::*;

  localparam int SAVE_BYTES  = 32768;
  localparam int CHUNK_BYTES = 64;
  localparam int NUM_CHUNKS  = SAVE_BYTES / CHUNK_BYTES;
  // Receiver hold-off used to back the core up into its input channel
  localparam int LONG_HOLD   = 400;

  // Shadow of the save RAM: applies each accepted request and queues the
  // responses it must produce, then checks the core's responses in order.
  class save_ram_shadow;
    logic [7:0]  save_mem [SAVE_BYTES];
    bit          chunk_dirty [NUM_CHUNKS];
    int unsigned scan_origin;
    int unsigned dirty_total;
    int unsigned save_size;
    logic [15:0] cart_sum;
    out_item_t   awaited_responses [$];
    int unsigned mismatches;

    function new();
      foreach (save_mem[i]) save_mem[i] = ERASED_BYTE;
      foreach (chunk_dirty[i]) chunk_dirty[i] = 1'b0;
      scan_origin  = 0;
      dirty_total  = 0;
      save_size    = SAVE_SIZE_RESET;
      cart_sum     = '0;
      mismatches   = 0;
    endfunction

    function int unsigned used_bytes();
      return (save_size > SAVE_BYTES) ? SAVE_BYTES : save_size;
    endfunction

    function int unsigned used_chunks();
      return (used_bytes() + CHUNK_BYTES - 1) / CHUNK_BYTES;
    endfunction

    function logic [7:0] stored_byte(int unsigned addr);
      return save_mem[addr];
    endfunction

    function void apply_reg(logic idx, logic [15:0] value);
      int unsigned kept;
      if (idx == REG_SAVE_SIZE) begin
        save_size = value;
        kept = used_chunks();
        // Chunks wholly beyond the new size lose their dirty mark
        for (int unsigned c = kept; c < NUM_CHUNKS; c++) begin
          if (chunk_dirty[c]) begin
            chunk_dirty[c] = 1'b0;
            dirty_total--;
          end
        end
      end else begin
        cart_sum = value;
      end
    endfunction

    function void push_response(logic [1:0] kind, logic [7:0] data, logic acc,
                                logic [31:0] key, logic [5:0] offset, logic last);
      out_item_t r;
      r.kind        = kind;
      r.byte_out    = data;
      r.accepted    = acc;
      r.chunk_key   = key;
      r.byte_offset = offset;
      r.last        = last;
      r.dirty_count = 10'(dirty_total);
      awaited_responses.push_back(r);
    endfunction

    function void note_request(in_item_t req);
      int unsigned size, addr, n, start, c, base, len;
      logic [31:0] key;
      bit          in_range, found;
      size     = used_bytes();
      addr     = req.address;
      in_range = addr < size;
      found    = 1'b0;
      case (req.op)
        OP_READ: begin
          push_response(KIND_READ, in_range ? save_mem[addr] : ERASED_BYTE,
                        1'b0, '0, '0, 1'b1);
        end
        OP_WRITE: begin
          // Refuse out-of-range writes and writes that change nothing
          if (in_range && save_mem[addr] != req.byte_in) begin
            save_mem[addr] = req.byte_in;
            c = addr / CHUNK_BYTES;
            if (!chunk_dirty[c]) begin
              chunk_dirty[c] = 1'b1;
              dirty_total++;
            end
            push_response(KIND_STATUS, 8'h00, 1'b1, '0, '0, 1'b1);
          end else begin
            push_response(KIND_STATUS, 8'h00, 1'b0, '0, '0, 1'b1);
          end
        end
        OP_LOAD: begin
          // Restore without touching the dirty bits
          if (in_range) save_mem[addr] = req.byte_in;
          push_response(KIND_STATUS, 8'h00, in_range, '0, '0, 1'b1);
        end
        default: begin
          n = used_chunks();
          if (n != 0) begin
            start = scan_origin % n;
            for (int unsigned i = 0; i < n && !found; i++) begin
              c = (start + i) % n;
              if (chunk_dirty[c]) begin
                found = 1'b1;
                base  = c * CHUNK_BYTES;
                len   = size - base;
                if (len > CHUNK_BYTES) len = CHUNK_BYTES;
                key = KEY_PREFIX | {8'h00, cart_sum, 8'h00} | 32'(c);
                chunk_dirty[c] = 1'b0;
                dirty_total--;
                scan_origin = (c + 1) % n;
                for (int unsigned j = 0; j < len; j++) begin
                  push_response(KIND_FLUSH, save_mem[base + j], 1'b0, key, 6'(j),
                                j + 1 == len);
                end
              end
            end
          end
          if (!found) push_response(KIND_NONE, 8'h00, 1'b0, '0, '0, 1'b1);
        end
      endcase
    endfunction

    function void field_check(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_responses.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual 0x%h", $time, got);
        mismatches++;
        return;
      end
      want = awaited_responses.pop_front();
      field_check("kind", want.kind, got.kind);
      field_check("byte_out", want.byte_out, got.byte_out);
      field_check("accepted", want.accepted, got.accepted);
      field_check("chunk_key", want.chunk_key, got.chunk_key);
      field_check("byte_offset", want.byte_offset, got.byte_offset);
      field_check("last", want.last, got.last);
      field_check("dirty_count", want.dirty_count, got.dirty_count);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  save_ram_shadow shadow;
  // Gap modes flip now and then so that busy and quiet stretches alternate
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  // Each increment asks the response side for one long hold-off
  int hold_requests = 0;

  always #6 clk = ~clk;

  save_ram_dirty_chunk_writeback_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Offer one request and hold it until the core takes it. Called and left at
  // a falling edge; valid stays up so back-to-back transactions need no gap.
  task automatic issue(logic [1:0] op, int unsigned addr, logic [7:0] value);
    in_item_t req;
    int       gap;
    req.op      = op;
    req.address = 15'(addr);
    req.byte_in = value;
    gap = send_gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Accepted at this edge: predict before anything else can change state
    shadow.note_request(req);
    @(negedge clk);
  endtask

  // Drop valid, wait for every predicted response, then let trailing scans
  // and sweeps settle before the core counts as idle.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(negedge clk);
    while (shadow.awaited_responses.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    while (in_stall) @(negedge clk);
  endtask

  // Write one register while idle; a size write may start a dirty-bit sweep,
  // so wait for the input side to open again afterwards.
  task automatic write_reg(logic idx, logic [15:0] value);
    while (in_stall) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow.apply_reg(idx, value);
    repeat (4) @(negedge clk);
    while (in_stall) @(negedge clk);
  endtask

  // Mostly addresses in a hot window so that reads see earlier writes and
  // flushes find dirty chunks; some spread over the used size, some anywhere.
  task automatic random_request(int unsigned hot_span);
    int unsigned pick, used, span, addr;
    logic [1:0]  op;
    logic [7:0]  value;
    used = shadow.used_bytes();
    pick = $urandom_range(0, 99);
    if (pick < 30) op = OP_READ;
    else if (pick < 65) op = OP_WRITE;
    else if (pick < 80) op = OP_LOAD;
    else op = OP_FLUSH;
    span = (hot_span < used) ? hot_span : used;
    pick = $urandom_range(0, 99);
    if (used == 0 || pick < 15) addr = $urandom_range(0, SAVE_BYTES - 1);
    else if (pick < 40) addr = $urandom_range(0, used - 1);
    else addr = $urandom_range(0, span - 1);
    // Repeat the stored byte now and then to hit the equal-value refusal
    value = ($urandom_range(0, 4) == 0) ? shadow.stored_byte(addr) : 8'($urandom);
    issue(op, addr, value);
  endtask

  task automatic run_phase(logic [15:0] size, logic [15:0] checksum, int n_items,
                           int unsigned hot_span, bit long_hold);
    quiesce();
    write_reg(REG_SAVE_SIZE, size);
    write_reg(REG_ROM_CHECKSUM, checksum);
    if (long_hold) begin
      // Stop draining for a while and keep offering requests at full rate
      send_gaps = 1'b0;
      hold_requests++;
    end
    for (int i = 0; i < n_items; i++) begin
      if ((!long_hold || i >= 30) && $urandom_range(0, 29) == 0) send_gaps = !send_gaps;
      random_request(hot_span);
    end
  endtask

  initial begin : stimulus
    shadow    = new();
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_SAVE_SIZE;
    cfg_data  = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed: default size, erased memory; the first request also rides
    // out the clearing pass behind in_stall.
    issue(OP_READ, 0, 8'h00);
    issue(OP_READ, SAVE_BYTES - 1, 8'h00);
    issue(OP_FLUSH, 0, 8'h00);                 // nothing dirty yet
    issue(OP_WRITE, 0, 8'h00);
    issue(OP_WRITE, 0, 8'h00);                 // same value, refused
    issue(OP_WRITE, SAVE_BYTES - 1, 8'hFF);    // equals erased byte, refused
    issue(OP_WRITE, SAVE_BYTES - 1, 8'h5A);    // dirties the top chunk
    issue(OP_LOAD, 5, 8'hFF);                  // load stores even if unchanged
    issue(OP_LOAD, 64, 8'h12);                 // load leaves chunk clean
    issue(OP_WRITE, 300 * CHUNK_BYTES, 8'hA5);
    issue(OP_READ, 64, 8'h00);
    issue(OP_FLUSH, 0, 8'h00);                 // chunk 0
    issue(OP_FLUSH, 0, 8'h00);                 // chunk 300, cursor moves to 301
    issue(OP_WRITE, 100, 8'h80);
    issue(OP_WRITE, 200, 8'h7F);

    // Shrink to 16 chunks: the top chunk drops its dirty mark and the cursor
    // now points past the end, so the scan wraps around.
    quiesce();
    write_reg(REG_SAVE_SIZE, 16'd1000);
    write_reg(REG_ROM_CHECKSUM, 16'hFFFF);
    issue(OP_FLUSH, 0, 8'h00);
    issue(OP_READ, 1000, 8'h00);               // out of range reads as erased
    issue(OP_LOAD, 1000, 8'h44);               // out of range, refused
    issue(OP_WRITE, 999, 8'h01);               // partial last chunk
    issue(OP_FLUSH, 0, 8'h00);
    issue(OP_FLUSH, 0, 8'h00);

    // Zero size: everything out of range, flush finds nothing
    quiesce();
    write_reg(REG_SAVE_SIZE, 16'd0);
    issue(OP_WRITE, 0, 8'h11);
    issue(OP_FLUSH, 0, 8'h00);

    // One byte in use: a flush emits a single last byte
    quiesce();
    write_reg(REG_SAVE_SIZE, 16'd1);
    issue(OP_WRITE, 0, 8'h33);
    issue(OP_FLUSH, 0, 8'h00);

    // Random phases across sizes and checksums, extremes included
    run_phase(16'd32768, 16'($urandom), 80, 1024, 1'b0);
    run_phase(16'd64, 16'hFFFF, 50, 64, 1'b0);
    run_phase(16'($urandom_range(65, 700)), 16'($urandom), 60, 700, 1'b0);
    run_phase(16'hFFFF, 16'h0000, 70, 4096, 1'b0);
    run_phase(16'd300, 16'($urandom), 50, 300, 1'b1);
    run_phase(16'($urandom_range(1, 32768)), 16'h0000, 60, 2048, 1'b0);
    run_phase(16'd0, 16'($urandom), 15, 1, 1'b0);
    run_phase(16'd32768, 16'hFFFF, 70, 1024, 1'b0);
    run_phase(16'd1, 16'($urandom), 20, 1, 1'b0);

    // Drain, then give any stray response time to show up
    quiesce();
    repeat (40) @(negedge clk);
    if (shadow.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Response side: stall a random number of cycles before each transaction,
  // or for a long stretch when asked, then take and check one response.
  initial begin : response_sink
    int pause;
    int holds_served;
    holds_served = 0;
    out_stall    = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        pause = LONG_HOLD;
      end else begin
        if ($urandom_range(0, 39) == 0) recv_gaps = !recv_gaps;
        pause = recv_gaps ? $urandom_range(0, 12) : 0;
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      shadow.check_result(out_data);
    end
  end

  // Hard stop well beyond the slowest legal run, clearing pass included
  initial begin : watchdog
    #(50_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
